// File: design/obddtc_pkg.sv
// ----------------------------------------------------------------------------
// obddtc_pkg: shared types and constants for the DTC response parser
// Parse modes and phases, result record, per-beat push record, char codes.
// ----------------------------------------------------------------------------
package obddtc_pkg;

    // upper bound on codes taken from one response (1..16)
    localparam int CODE_LIMIT_MAX = 16;

    localparam int CFG_W      = 5;
    localparam int CAP_W      = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int M_DATA_W   = 40;

    localparam logic [CFG_W-1:0] CODE_LIMIT_RST = 5'd16;

    localparam logic [7:0] HDR_BIN  = 8'h43;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_UNDEC = 2'd0,
        MODE_BIN   = 2'd1,
        MODE_ASCII = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        PH_SEARCH    = 4'd0,
        PH_AFTER_HDR = 4'd1,
        PH_HI0       = 4'd2,
        PH_HI1       = 4'd3,
        PH_SEP1      = 4'd4,
        PH_LO0       = 4'd5,
        PH_LO1       = 4'd6,
        PH_SEP2      = 4'd7,
        PH_DONE      = 4'd8
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] code_index;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] category;
        logic [1:0] first_digit;
        logic [3:0] middle_nibble;
        logic [4:0] code_count;
        logic       codes_present;
        logic       last;
    } res_t;

    // results caused by one input beat, in order
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_val = {1'b0, d[3:0]};
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
                hex_val = {1'b0, d[3:0]};
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
                hex_val = {1'b0, d[3:0]};
            end else begin
                hex_val = 5'h10;
            end
        end
    endfunction

endpackage

// File: design/obddtc_parse.sv
// ----------------------------------------------------------------------------
// obddtc_parse: per-byte parse state and result formation
// Holds the reply state; one beat updates it and yields up to two results.
// ----------------------------------------------------------------------------
module obddtc_parse #(
    parameter int CODE_LIMIT_MAX = obddtc_pkg::CODE_LIMIT_MAX
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          beat_en,
    input  logic [7:0]                    resp_byte,
    input  logic                          last_byte,
    input  logic [obddtc_pkg::CFG_W-1:0]  code_limit,
    output obddtc_pkg::push_t             push
);

    obddtc_pkg::mode_t  mode_reg,  mode_next;
    obddtc_pkg::phase_t phase_reg, phase_next;
    logic [7:0] prev_reg,  prev_next;
    logic [1:0] pos_reg,   pos_next;
    logic [7:0] hi_reg,    hi_next;
    logic [3:0] nib_reg,   nib_next;
    logic [4:0] fc_reg,    fc_next;

    logic [4:0] hex;
    logic       hex_ok;
    logic       asc, hi0_go, lo0_go, code_v;
    logic [7:0] code_lo;
    logic [obddtc_pkg::CAP_W-1:0] cap, fc_wide;
    logic       at_cap;
    obddtc_pkg::res_t code_res, end_res;

    always_comb begin
        if ({2'b00, code_limit} < obddtc_pkg::CAP_W'(CODE_LIMIT_MAX)) begin
            cap = {2'b00, code_limit};
        end else begin
            cap = obddtc_pkg::CAP_W'(CODE_LIMIT_MAX);
        end
        fc_wide = {2'b00, fc_reg};
        at_cap  = (fc_wide >= cap);
    end

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hi_next    = hi_reg;
        nib_next   = nib_reg;
        fc_next    = fc_reg;
        prev_next  = resp_byte;
        hex        = obddtc_pkg::hex_val(resp_byte);
        hex_ok     = !hex[4];
        asc        = 1'b0;
        hi0_go     = 1'b0;
        lo0_go     = 1'b0;
        code_v     = 1'b0;
        code_lo    = resp_byte;

        case (mode_reg)
            obddtc_pkg::MODE_UNDEC: begin
                if (resp_byte == obddtc_pkg::HDR_BIN) begin
                    mode_next = obddtc_pkg::MODE_BIN;
                    pos_next  = 2'd0;
                end else begin
                    mode_next = obddtc_pkg::MODE_ASCII;
                    asc       = 1'b1;
                end
            end
            obddtc_pkg::MODE_BIN: begin
                if (pos_reg == 2'd0) begin
                    pos_next = 2'd1;
                end else if (pos_reg == 2'd1) begin
                    hi_next  = resp_byte;
                    pos_next = 2'd2;
                end else begin
                    code_v   = !at_cap;
                    pos_next = 2'd1;
                end
            end
            default: begin
                asc = 1'b1;
            end
        endcase

        if (asc) begin
            case (phase_reg)
                obddtc_pkg::PH_SEARCH: begin
                    if (prev_reg == obddtc_pkg::CH_FOUR &&
                        resp_byte == obddtc_pkg::CH_THREE) begin
                        phase_next = obddtc_pkg::PH_AFTER_HDR;
                    end
                end
                obddtc_pkg::PH_AFTER_HDR, obddtc_pkg::PH_SEP2: begin
                    phase_next = obddtc_pkg::PH_HI0;
                    hi0_go     = (resp_byte != obddtc_pkg::CH_SPACE);
                end
                obddtc_pkg::PH_HI0: begin
                    hi0_go = 1'b1;
                end
                obddtc_pkg::PH_HI1: begin
                    if (!hex_ok) begin
                        phase_next = obddtc_pkg::PH_DONE;
                    end else begin
                        hi_next    = {nib_reg, hex[3:0]};
                        phase_next = obddtc_pkg::PH_SEP1;
                    end
                end
                obddtc_pkg::PH_SEP1: begin
                    phase_next = obddtc_pkg::PH_LO0;
                    lo0_go     = (resp_byte != obddtc_pkg::CH_SPACE);
                end
                obddtc_pkg::PH_LO0: begin
                    lo0_go = 1'b1;
                end
                obddtc_pkg::PH_LO1: begin
                    if (!hex_ok) begin
                        phase_next = obddtc_pkg::PH_DONE;
                    end else begin
                        code_v     = 1'b1;
                        code_lo    = {nib_reg, hex[3:0]};
                        phase_next = obddtc_pkg::PH_SEP2;
                    end
                end
                default: begin
                    phase_next = obddtc_pkg::PH_DONE;
                end
            endcase
        end

        // high nibble of a new code: also where the cap stops parsing
        if (hi0_go) begin
            if (at_cap || !hex_ok) begin
                phase_next = obddtc_pkg::PH_DONE;
            end else begin
                nib_next   = hex[3:0];
                phase_next = obddtc_pkg::PH_HI1;
            end
        end
        if (lo0_go) begin
            if (!hex_ok) begin
                phase_next = obddtc_pkg::PH_DONE;
            end else begin
                nib_next   = hex[3:0];
                phase_next = obddtc_pkg::PH_LO1;
            end
        end

        if (code_v) begin
            fc_next = fc_reg + 5'd1;
        end

        code_res               = '0;
        code_res.kind          = obddtc_pkg::KIND_CODE;
        code_res.code_index    = fc_reg[3:0];
        code_res.first_byte    = hi_reg;
        code_res.second_byte   = code_lo;
        code_res.category      = hi_reg[7:6];
        code_res.first_digit   = hi_reg[5:4];
        code_res.middle_nibble = hi_reg[3:0];
        code_res.last          = !last_byte;

        end_res               = '0;
        end_res.kind          = obddtc_pkg::KIND_END;
        end_res.code_count    = fc_next;
        end_res.codes_present = (fc_next != 5'd0);
        end_res.last          = 1'b1;

        push.cnt    = {1'b0, code_v} + {1'b0, last_byte};
        push.first  = code_v ? code_res : end_res;
        push.second = end_res;

        // end of reply rearms for the next one
        if (last_byte) begin
            mode_next  = obddtc_pkg::MODE_UNDEC;
            phase_next = obddtc_pkg::PH_SEARCH;
            prev_next  = 8'h00;
            pos_next   = 2'd0;
            hi_next    = 8'h00;
            nib_next   = 4'h0;
            fc_next    = 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= obddtc_pkg::MODE_UNDEC;
            phase_reg <= obddtc_pkg::PH_SEARCH;
            prev_reg  <= 8'h00;
            pos_reg   <= 2'd0;
            hi_reg    <= 8'h00;
            nib_reg   <= 4'h0;
            fc_reg    <= 5'd0;
        end else if (beat_en) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            pos_reg   <= pos_next;
            hi_reg    <= hi_next;
            nib_reg   <= nib_next;
            fc_reg    <= fc_next;
        end
    end

endmodule

// File: design/obddtc_fifo.sv
// ----------------------------------------------------------------------------
// obddtc_fifo: small result queue
// Takes up to two results per push, hands out one per pop.
// ----------------------------------------------------------------------------
module obddtc_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_en,
    input  obddtc_pkg::push_t   push,
    input  logic                pop,
    output obddtc_pkg::res_t    head,
    output logic                head_valid,
    output logic                room
);

    obddtc_pkg::res_t mem [obddtc_pkg::FIFO_DEPTH];

    logic [obddtc_pkg::FIFO_AW-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [obddtc_pkg::FIFO_CW-1:0] cnt_reg, cnt_next;
    logic [1:0] n_in;
    logic       do_pop;

    always_comb begin
        n_in     = push_en ? push.cnt : 2'd0;
        do_pop   = pop && (cnt_reg != '0);
        wr_plus1 = wr_reg + obddtc_pkg::FIFO_AW'(1);
        wr_next  = wr_reg + obddtc_pkg::FIFO_AW'(n_in);
        rd_next  = rd_reg + obddtc_pkg::FIFO_AW'(do_pop);
        cnt_next = cnt_reg + obddtc_pkg::FIFO_CW'(n_in) - obddtc_pkg::FIFO_CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (n_in == 2'd2) begin
            mem[wr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head       = mem[rd_reg];
    assign head_valid = (cnt_reg != '0);
    // room for a full two-result beat
    assign room       = (cnt_reg <= obddtc_pkg::FIFO_CW'(obddtc_pkg::FIFO_DEPTH - 2));

endmodule

// File: design/obd_dtc_response_parser.sv
// ----------------------------------------------------------------------------
// obd_dtc_response_parser: OBD-II mode 03 trouble-code reply parser
// Binary or ASCII reply bytes in; decoded codes and an end summary out.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | tdata[7:0] resp_byte, tlast last_byte
//  m_axis   | out | tdata code/summary fields, tuser kind, tlast on summary and on codes from non-final bytes
//  cfg      | in  | cfg_data[4:0] code limit
//
//  One reply byte per cycle; each byte is parsed in the cycle it is taken.
//  A byte gives up to two results (a code and, on tlast, the end summary);
//  they drain one per cycle while m_tready is high, through a four-entry
//  result queue, so bytes that give two results each are held back by it.
//  s_tready drops only when the queue lacks room for two results.
//  Synchronous active-low reset; the code limit resets to 16.
// ----------------------------------------------------------------------------
module obd_dtc_response_parser #(
    parameter int CODE_LIMIT_MAX = obddtc_pkg::CODE_LIMIT_MAX
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] resp_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] code_index, [11:4] first_byte, [19:12] second_byte,
    // [21:20] category, [23:22] first_digit, [27:24] middle_nibble,
    // [32:28] code_count, [33] codes_present, [39:34] zero
    output logic [obddtc_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // [0] kind
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [obddtc_pkg::CFG_W-1:0]        cfg_data
);

    logic [obddtc_pkg::CFG_W-1:0] code_limit_reg;
    logic                         beat;
    logic                         room;
    obddtc_pkg::push_t            push;
    obddtc_pkg::res_t             head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_limit_reg <= obddtc_pkg::CODE_LIMIT_RST;
        end else if (cfg_valid) begin
            code_limit_reg <= cfg_data;
        end
    end

    assign s_tready = room;
    assign beat     = s_tvalid && room;

    obddtc_parse #(
        .CODE_LIMIT_MAX (CODE_LIMIT_MAX)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_en    (beat),
        .resp_byte  (s_tdata),
        .last_byte  (s_tlast),
        .code_limit (code_limit_reg),
        .push       (push)
    );

    obddtc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (beat),
        .push       (push),
        .pop        (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .room       (room)
    );

    assign m_tdata = {6'd0, head.codes_present, head.code_count, head.middle_nibble,
                      head.first_digit, head.category, head.second_byte,
                      head.first_byte, head.code_index};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
